>>> rtl/assert_macros.svh
// Assertion macros shared by checker files.
// Include guarded; holds only macro definitions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/ecpa_pkg.sv
// Package for the EC point add/double core: widths, state encodings.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ecpa_pkg;
    localparam int FIELD_BITS_DEF = 16;
    localparam int REG_MODULUS = 0;
    localparam int REG_CURVE_A = 1;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_RED
    } alu_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RED,
        S_CMP,
        S_SQ,
        S_NUM1,
        S_NUM2,
        S_NUM3,
        S_DEN,
        S_DIFF_N,
        S_DIFF_D,
        S_INV_INIT,
        S_INV_DIV,
        S_INV_QMUL,
        S_INV_TSUB,
        S_INV_CHK,
        S_SLOPE,
        S_MSQ,
        S_X3A,
        S_X3B,
        S_DX,
        S_MY,
        S_Y3,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

>>> rtl/ecpa_alu.sv
// Shared modular ALU: add, sub, bit-serial multiply, bit-serial reduce/divide.
// Depends on ecpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ecpa_alu
    import ecpa_pkg::*;
#(
    parameter int FIELD_BITS = FIELD_BITS_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire alu_op_t               op,
    input  wire logic [FIELD_BITS-1:0] opa,
    input  wire logic [FIELD_BITS-1:0] opb,
    input  wire logic [FIELD_BITS-1:0] modulus,
    output logic                       done,
    output logic [FIELD_BITS-1:0]      result,
    output logic [FIELD_BITS-1:0]      quot
);
    localparam int CW = $clog2(FIELD_BITS + 1);

    logic                  busy_reg, busy_next;
    alu_op_t               op_reg, op_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [FIELD_BITS-1:0] acc_reg, acc_next;
    logic [FIELD_BITS-1:0] a_reg, a_next;
    logic [FIELD_BITS-1:0] b_reg, b_next;
    logic [FIELD_BITS-1:0] q_reg, q_next;
    logic                  done_reg, done_next;

    // modular add of values already below m
    function automatic logic [FIELD_BITS-1:0] madd(input logic [FIELD_BITS-1:0] x,
        input logic [FIELD_BITS-1:0] y, input logic [FIELD_BITS-1:0] m);
        logic [FIELD_BITS-1:0] gap;
        gap = m - y;
        return (x >= gap) ? x - gap : x + y;
    endfunction

    logic [FIELD_BITS:0] rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        q_next    = q_reg;
        done_next = 1'b0;
        rem_sh    = {acc_reg, a_reg[FIELD_BITS-1]};
        if (!busy_reg)
        begin
            if (start)
            begin
                op_next = op;
                unique case (op)
                    ALU_ADD:
                    begin
                        acc_next  = madd(opa, opb, modulus);
                        done_next = 1'b1;
                    end
                    ALU_SUB:
                    begin
                        acc_next  = (opa >= opb) ? opa - opb : opa + (modulus - opb);
                        done_next = 1'b1;
                    end
                    ALU_MUL:
                    begin
                        busy_next = 1'b1;
                        acc_next  = '0;
                        a_next    = opa;
                        b_next    = opb;
                        cnt_next  = CW'(FIELD_BITS);
                    end
                    default:
                    begin
                        // restoring division of opa by opb
                        busy_next = 1'b1;
                        acc_next  = '0;
                        a_next    = opa;
                        b_next    = opb;
                        q_next    = '0;
                        cnt_next  = CW'(FIELD_BITS);
                    end
                endcase
            end
        end
        else
        begin
            if (op_reg == ALU_MUL)
            begin
                if (b_reg[0])
                    acc_next = madd(acc_reg, a_reg, modulus);
                a_next = madd(a_reg, a_reg, modulus);
                b_next = b_reg >> 1;
            end
            else
            begin
                a_next = a_reg << 1;
                if (rem_sh >= {1'b0, b_reg})
                begin
                    acc_next = FIELD_BITS'(rem_sh - {1'b0, b_reg});
                    q_next   = {q_reg[FIELD_BITS-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_sh[FIELD_BITS-1:0];
                    q_next   = {q_reg[FIELD_BITS-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_ADD;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        q_reg   <= q_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;
    assign quot   = q_reg;
endmodule
`default_nettype wire

>>> rtl/ec_point_add_double_mod_p_core.sv
// EC affine point add/double core: sequencer plus register file.
// Depends on ecpa_pkg and ecpa_alu.
`timescale 1ns / 1ps
`default_nettype none
// One request computes P+Q (or 2P when equal) modulo the configured p. All
// arithmetic runs on one shared ALU, whose multiply and divide are
// bit-serial. The inverse is extended Euclid, one divide, one multiply and
// one subtract per step. A modulus below two gives infinity. Input is not
// ready while busy; the result sits in an output register and the next
// request is accepted from the cycle after the result has been taken.
module ec_point_add_double_mod_p_core
    import ecpa_pkg::*;
#(
    parameter int FIELD_BITS = FIELD_BITS_DEF
)(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [0:0]              cfg_index,
    input  wire logic [FIELD_BITS-1:0]   cfg_data,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // first_x, first_y, second_x, second_y (low to high)
    input  wire logic [4*FIELD_BITS-1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // sum_x, sum_y (low to high)
    output logic [2*FIELD_BITS-1:0]      m_tdata,
    // at_infinity
    output logic                         m_tuser
);
    localparam int FB = FIELD_BITS;

    state_t state_reg, state_next;
    logic [FB-1:0] mod_reg, ca_reg;
    logic [FB-1:0] x1_reg, y1_reg, x2_reg, y2_reg, a_reg;
    logic [FB-1:0] num_reg, den_reg, sq_reg, m_reg;
    logic [FB-1:0] r0_reg, r1_reg, t0_reg, t1_reg, q_reg, tmp_reg;
    logic [FB-1:0] x3_reg, y3_reg;
    logic [2:0]    idx_reg;
    logic          busy_reg;
    logic          ov_reg;
    logic [2*FB-1:0] od_reg;
    logic          oinf_reg;
    logic          oinf_keep;

    logic          alu_start, alu_done;
    alu_op_t       alu_op;
    logic [FB-1:0] alu_a, alu_b, alu_res, alu_q;

    ecpa_alu #(.FIELD_BITS(FIELD_BITS)) u_alu (
        .clk(clk), .rst_n(rst_n), .start(alu_start), .op(alu_op),
        .opa(alu_a), .opb(alu_b), .modulus(mod_reg),
        .done(alu_done), .result(alu_res), .quot(alu_q)
    );

    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    logic in_acc;
    assign in_acc = s_tvalid && s_tready;

    logic [FB-1:0] red_src;
    always_comb
    begin
        unique case (idx_reg)
            3'd0:    red_src = x1_reg;
            3'd1:    red_src = y1_reg;
            3'd2:    red_src = x2_reg;
            3'd3:    red_src = y2_reg;
            default: red_src = a_reg;
        endcase
    end

    // next state and ALU issue; operand issued while ALU idle (busy_reg low)
    always_comb
    begin
        state_next = state_reg;
        alu_start  = 1'b0;
        alu_op     = ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;
        unique case (state_reg)
            S_IDLE:     if (in_acc) state_next = (mod_reg < FB'(2)) ? S_OUT : S_RED;
            S_RED:      begin alu_op = ALU_RED; alu_a = red_src; alu_b = mod_reg; end
            S_CMP:      state_next = (x1_reg == x2_reg && y1_reg == y2_reg) ? S_SQ : S_DIFF_N;
            S_SQ:       begin alu_op = ALU_MUL; alu_a = x1_reg; alu_b = x1_reg; end
            S_NUM1:     begin alu_a = sq_reg; alu_b = sq_reg; end
            S_NUM2:     begin alu_a = num_reg; alu_b = sq_reg; end
            S_NUM3:     begin alu_a = num_reg; alu_b = a_reg; end
            S_DEN:      begin alu_a = y1_reg; alu_b = y1_reg; end
            S_DIFF_N:   begin alu_op = ALU_SUB; alu_a = y2_reg; alu_b = y1_reg; end
            S_DIFF_D:   begin alu_op = ALU_SUB; alu_a = x2_reg; alu_b = x1_reg; end
            S_INV_INIT: state_next = S_INV_CHK;
            S_INV_DIV:  begin alu_op = ALU_RED; alu_a = r0_reg; alu_b = r1_reg; end
            S_INV_QMUL: begin alu_op = ALU_MUL; alu_a = q_reg; alu_b = t1_reg; end
            S_INV_TSUB: begin alu_op = ALU_SUB; alu_a = t0_reg; alu_b = tmp_reg; end
            S_INV_CHK:  if (r1_reg == '0) state_next = S_SLOPE;
                        else state_next = S_INV_DIV;
            S_SLOPE:    begin alu_op = ALU_MUL; alu_a = num_reg; alu_b = t0_reg; end
            S_MSQ:      begin alu_op = ALU_MUL; alu_a = m_reg; alu_b = m_reg; end
            S_X3A:      begin alu_op = ALU_SUB; alu_a = tmp_reg; alu_b = x1_reg; end
            S_X3B:      begin alu_op = ALU_SUB; alu_a = tmp_reg; alu_b = x2_reg; end
            S_DX:       begin alu_op = ALU_SUB; alu_a = x1_reg; alu_b = x3_reg; end
            S_MY:       begin alu_op = ALU_MUL; alu_a = m_reg; alu_b = tmp_reg; end
            S_Y3:       begin alu_op = ALU_SUB; alu_a = tmp_reg; alu_b = y1_reg; end
            S_OUT:      state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
        if (state_reg != S_IDLE && state_reg != S_CMP && state_reg != S_INV_INIT &&
            state_reg != S_INV_CHK && state_reg != S_OUT)
        begin
            alu_start = !busy_reg;
            if (alu_done)
            begin
                unique case (state_reg)
                    S_RED:      state_next = (idx_reg == 3'd4) ? S_CMP : S_RED;
                    S_SQ:       state_next = S_NUM1;
                    S_NUM1:     state_next = S_NUM2;
                    S_NUM2:     state_next = S_NUM3;
                    S_NUM3:     state_next = S_DEN;
                    S_DEN:      state_next = S_INV_INIT;
                    S_DIFF_N:   state_next = S_DIFF_D;
                    S_DIFF_D:   state_next = S_INV_INIT;
                    S_INV_DIV:  state_next = S_INV_QMUL;
                    S_INV_QMUL: state_next = S_INV_TSUB;
                    S_INV_TSUB: state_next = S_INV_CHK;
                    S_SLOPE:    state_next = S_MSQ;
                    S_MSQ:      state_next = S_X3A;
                    S_X3A:      state_next = S_X3B;
                    S_X3B:      state_next = S_DX;
                    S_DX:       state_next = S_MY;
                    S_MY:       state_next = S_Y3;
                    default:    state_next = S_OUT;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mod_reg   <= FB'(17);
            ca_reg    <= FB'(2);
            busy_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == 1'(REG_MODULUS)) mod_reg <= cfg_data;
                else                              ca_reg  <= cfg_data;
            end
            if (alu_done)       busy_reg <= 1'b0;
            else if (alu_start) busy_reg <= 1'b1;
            if (in_acc)
                idx_reg <= '0;
            else if (state_reg == S_RED && alu_done)
                idx_reg <= idx_reg + 3'd1;
            if (state_reg == S_OUT)
                ov_reg <= 1'b1;
            else if (m_tready)
                ov_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x1_reg <= s_tdata[FB-1:0];
            y1_reg <= s_tdata[2*FB-1:FB];
            x2_reg <= s_tdata[3*FB-1:2*FB];
            y2_reg <= s_tdata[4*FB-1:3*FB];
            a_reg  <= ca_reg;
            oinf_reg <= 1'b1;
        end
        if (state_reg == S_INV_INIT)
        begin
            r0_reg <= mod_reg;
            r1_reg <= den_reg;
            t0_reg <= '0;
            t1_reg <= FB'(1);
        end
        if (state_reg == S_INV_CHK && r1_reg == '0)
            oinf_reg <= (r0_reg != FB'(1));
        if (alu_done)
        begin
            unique case (state_reg)
                S_RED:
                begin
                    unique case (idx_reg)
                        3'd0:    x1_reg <= alu_res;
                        3'd1:    y1_reg <= alu_res;
                        3'd2:    x2_reg <= alu_res;
                        3'd3:    y2_reg <= alu_res;
                        default: a_reg  <= alu_res;
                    endcase
                end
                S_SQ:                       sq_reg  <= alu_res;
                S_NUM1, S_NUM2, S_NUM3,
                S_DIFF_N:                   num_reg <= alu_res;
                S_DEN, S_DIFF_D:            den_reg <= alu_res;
                S_INV_DIV:
                begin
                    // q mod p: q < p unless r0 = p, r1 = 1, where q = p maps to 0
                    q_reg  <= (alu_q >= mod_reg) ? alu_q - mod_reg : alu_q;
                    tmp_reg <= alu_res;
                end
                S_INV_QMUL:
                begin
                    r0_reg  <= r1_reg;
                    r1_reg  <= tmp_reg;
                    tmp_reg <= alu_res;
                end
                S_INV_TSUB:
                begin
                    t0_reg <= t1_reg;
                    t1_reg <= alu_res;
                end
                S_SLOPE:                    m_reg   <= alu_res;
                S_MSQ, S_X3A, S_DX, S_MY:   tmp_reg <= alu_res;
                S_X3B:                      x3_reg  <= alu_res;
                default:                    y3_reg  <= alu_res;
            endcase
        end
        if (state_reg == S_OUT)
        begin
            od_reg    <= oinf_reg ? '0 : {y3_reg, x3_reg};
            oinf_keep <= oinf_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = oinf_keep;
endmodule
`default_nettype wire

>>> rtl/ecpa_checker.sv
// Port-level checker for the EC point core, bound to the top level.
// Depends on ecpa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ecpa_checker
    import ecpa_pkg::*;
#(
    parameter int FIELD_BITS = FIELD_BITS_DEF
)(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [2*FIELD_BITS-1:0] m_tdata,
    input wire logic                  m_tuser
);
    // no new request while a result is pending
    `ASSERT_IMPL(a_no_in_while_out, clk, rst_n, m_tvalid, !s_tready)
    // an accepted request cannot be answered in the next cycle
    `ASSERT_NEXT(a_not_instant, clk, rst_n, s_tvalid && s_tready, !m_tvalid)
    // infinity reports zero coordinates
    `ASSERT_IMPL(a_inf_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == '0)
    // pending result holds
    `ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
bind ec_point_add_double_mod_p_core ecpa_checker #(.FIELD_BITS(FIELD_BITS)) u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

>>> verif/tb_top.sv
// Testbench for the EC affine point add/double core: random and directed requests,
// scoreboard with its own modular-arithmetic predictor. Depends on ecpa_pkg and the core.
`timescale 1ns / 1ps

class ecpa_scoreboard;
    bit [15:0] p_reg;
    bit [15:0] a_reg;
    bit [32:0] pending[$];
    int unsigned errors;

    function new();
        p_reg = 17;
        a_reg = 2;
        errors = 0;
    endfunction

    function bit [15:0] madd(bit [15:0] x, bit [15:0] y, bit [15:0] m);
        bit [15:0] gap;
        gap = m - y;
        return (x >= gap) ? x - gap : x + y;
    endfunction

    function bit [15:0] msub(bit [15:0] x, bit [15:0] y, bit [15:0] m);
        return (x >= y) ? x - y : x + (m - y);
    endfunction

    function bit [15:0] mmul(bit [15:0] x, bit [15:0] y, bit [15:0] m);
        bit [31:0] prod;
        prod = x * y;
        return 16'(prod % m);
    endfunction

    // extended Euclid; returns 0 when v has no inverse mod m
    function bit minv(bit [15:0] v, bit [15:0] m, output bit [15:0] res);
        bit [15:0] r0, r1, r2, t0, t1, t2, q;
        r0 = m; r1 = v; t0 = 0; t1 = 16'(1 % m);
        while (r1 != 0) begin
            q = r0 / r1;
            r2 = r0 - q * r1;
            t2 = msub(t0, mmul(q % m, t1, m), m);
            r0 = r1; r1 = r2;
            t0 = t1; t1 = t2;
        end
        res = t0;
        return r0 == 1;
    endfunction

    function void note_request(bit [63:0] pts);
        bit [15:0] x1, y1, x2, y2, a, num, den, inv, sl, x3, y3, sq;
        if (p_reg < 2) begin
            pending.push_back({1'b1, 32'd0});
            return;
        end
        x1 = pts[15:0] % p_reg;  y1 = pts[31:16] % p_reg;
        x2 = pts[47:32] % p_reg; y2 = pts[63:48] % p_reg;
        a = a_reg % p_reg;
        if (x1 == x2 && y1 == y2) begin
            sq = mmul(x1, x1, p_reg);
            num = madd(madd(madd(sq, sq, p_reg), sq, p_reg), a, p_reg);
            den = madd(y1, y1, p_reg);
        end else begin
            num = msub(y2, y1, p_reg);
            den = msub(x2, x1, p_reg);
        end
        if (!minv(den, p_reg, inv)) begin
            pending.push_back({1'b1, 32'd0});
            return;
        end
        sl = mmul(num, inv, p_reg);
        x3 = msub(msub(mmul(sl, sl, p_reg), x1, p_reg), x2, p_reg);
        y3 = msub(mmul(sl, msub(x1, x3, p_reg), p_reg), y1, p_reg);
        pending.push_back({1'b0, y3, x3});
    endfunction

    function void check_sum(bit [31:0] data, bit inf);
        bit [32:0] exp_sum;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result x=%0d y=%0d inf=%0d", data[15:0], data[31:16], inf);
            return;
        end
        exp_sum = pending.pop_front();
        if (exp_sum[31:0] !== data || exp_sum[32] !== inf) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp x=%0d y=%0d inf=%0d, got x=%0d y=%0d inf=%0d",
                         exp_sum[15:0], exp_sum[31:16], exp_sum[32],
                         data[15:0], data[31:16], inf);
        end
    endfunction
endclass

module tb_top;
    import ecpa_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [0:0] cfg_index = 0;
    logic [15:0] cfg_data = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [63:0] s_tdata = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [31:0] m_tdata;
    logic m_tuser;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    ecpa_scoreboard sb = new();

    ec_point_add_double_mod_p_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    // result side: random stalls, check at rising edge
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_sum(m_tdata, m_tuser);
    end

    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic write_reg(input int idx, input bit [15:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= 1'(idx);
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        if (idx == REG_MODULUS)
            sb.p_reg = val;
        else
            sb.a_reg = val;
    endtask

    task automatic send_points(input bit [15:0] x1, y1, x2, y2);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
            @(negedge clk);
        s_tvalid <= 1;
        s_tdata <= {y2, x2, y1, x1};
        do @(posedge clk); while (!s_tready);
        sb.note_request({y2, x2, y1, x1});
        @(negedge clk);
        s_tvalid <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic bit [15:0] coord(bit [15:0] p);
        // mostly reduced values, occasionally any 16-bit pattern
        if ($urandom_range(19) == 0)
            return 16'($urandom);
        return (p == 0) ? 16'($urandom) : 16'($urandom_range(p - 1));
    endfunction

    // a random pair of points, weighted toward doubling, negation and equal x
    task automatic random_pair(input bit [15:0] p);
        bit [15:0] x1, y1, x2, y2;
        int pick;
        x1 = coord(p);
        y1 = coord(p);
        x2 = coord(p);
        y2 = coord(p);
        pick = $urandom_range(9);
        if (pick < 2) begin
            x2 = x1; y2 = y1;
        end else if (pick == 2 && p >= 2) begin
            x2 = x1; y2 = (p - (y1 % p)) % p;
        end else if (pick == 3) begin
            x2 = x1;
        end
        send_points(x1, y1, x2, y2);
    endtask

    initial begin
        bit [15:0] mods[8];
        bit [15:0] pm;
        int ph;
        mods = '{16'd17, 16'd3, 16'd65521, 16'd65535, 16'd251, 16'd4, 16'd0, 16'd1};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed, reset settings (p = 17, a = 2)
        send_points(16'd0, 16'd0, 16'd0, 16'd0);
        send_points(16'd5, 16'd1, 16'd5, 16'd1);
        send_points(16'd5, 16'd1, 16'd6, 16'd3);
        send_points(16'd5, 16'd1, 16'd5, 16'd16);
        send_points(16'd3, 16'd0, 16'd3, 16'd0);
        send_points(16'd16, 16'd16, 16'd0, 16'd0);
        send_points(16'hffff, 16'hffff, 16'hffff, 16'h0000);
        send_points(16'd22, 16'd1, 16'd5, 16'd1);
        drain();
        write_reg(REG_MODULUS, 16'd65521);
        write_reg(REG_CURVE_A, 16'd65520);
        send_points(16'd65520, 16'd65520, 16'd65520, 16'd65520);
        send_points(16'd0, 16'd65520, 16'd1, 16'd1);
        send_points(16'hffff, 16'h5555, 16'haaaa, 16'h0001);
        drain();
        write_reg(REG_CURVE_A, 16'hffff);
        write_reg(REG_MODULUS, 16'd15);
        send_points(16'd1, 16'd2, 16'd4, 16'd7);
        send_points(16'd3, 16'd4, 16'd3, 16'd4);
        send_points(16'd2, 16'd3, 16'd3, 16'd3);
        drain();
        write_reg(REG_MODULUS, 16'd0);
        send_points(16'd1, 16'd2, 16'd3, 16'd4);
        drain();
        write_reg(REG_MODULUS, 16'd1);
        send_points(16'd1, 16'd2, 16'd1, 16'd2);
        drain();

        // random phases: each a modulus and an idling mix
        for (ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 70; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 70; end
                default: begin src_idle_pct = 8; snk_stall_pct = 8; end
            endcase
            pm = (ph < 8) ? mods[ph] : 16'($urandom);
            write_reg(REG_MODULUS, pm);
            write_reg(REG_CURVE_A, (ph % 3 == 0) ? 16'd0 : 16'($urandom));
            repeat (120) random_pair(pm);
            src_idle_pct = 0;
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #200ms;
        $display("status: fail");
        $finish;
    end
endmodule
